// File: rtl/uart_packet_deframer_core_defines.svh
// ---------------------------------------------------------------------------
// uart packet deframer assertion macros
// shared property forms used by the top level checks
// ---------------------------------------------------------------------------
`ifndef UART_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define UART_PACKET_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define UPD_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("upd same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define UPD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("upd next-cycle check failed");

`endif

// File: rtl/upd_pkg.sv
// ---------------------------------------------------------------------------
// upd_pkg
// constants, state and control types for the uart packet deframer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

  localparam int BUF_SIZE = 64;
  localparam int IDX_W    = $clog2(BUF_SIZE);
  localparam int CNT_W    = IDX_W + 1;
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [7:0] START_CODE_RST = 8'h53;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_ERROR = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_READ,
    ST_LOAD
  } upd_state_t;

  typedef struct packed {
    logic in_ready;
    logic accept_byte;
    logic line_err;
    logic rd_issue;
    logic load_payload;
    logic load_single;
  } upd_cmd_t;

  typedef struct packed {
    logic complete;
    logic single;
    logic rd_last;
    logic out_free;
  } upd_sts_t;

endpackage

`default_nettype wire

// File: rtl/upd_in_if.sv
// ---------------------------------------------------------------------------
// upd_in_if
// receive event channel: op and received byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/upd_out_if.sv
// ---------------------------------------------------------------------------
// upd_out_if
// result channel: payload byte with status and last mark
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_data;
  logic       status;
  logic       last;

  modport source (output valid, output payload_byte, output has_data,
                  output status, output last, input ready);
  modport sink (input valid, input payload_byte, input has_data,
                input status, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/upd_cfg_if.sv
// ---------------------------------------------------------------------------
// upd_cfg_if
// configuration write channel for the start code register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface upd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/upd_ctrl.sv
// ---------------------------------------------------------------------------
// upd_ctrl
// frame controller: byte intake, result sequencing from the frame store
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_op,
  input  wire upd_pkg::upd_sts_t sts,
  output upd_pkg::upd_cmd_t     cmd
);

  upd_pkg::upd_state_t state;
  upd_pkg::upd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      upd_pkg::ST_IDLE: begin
        cmd.in_ready    = 1'b1;
        cmd.accept_byte = in_valid && (in_op == upd_pkg::OP_BYTE);
        cmd.line_err    = in_valid && (in_op == upd_pkg::OP_ERROR);
        if (cmd.accept_byte && sts.complete) begin
          state_next = sts.single ? upd_pkg::ST_SINGLE : upd_pkg::ST_READ;
        end
      end
      upd_pkg::ST_SINGLE: begin
        if (sts.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = upd_pkg::ST_IDLE;
        end
      end
      upd_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = upd_pkg::ST_LOAD;
      end
      upd_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_payload = 1'b1;
          state_next       = sts.rd_last ? upd_pkg::ST_IDLE : upd_pkg::ST_READ;
        end
      end
      default: begin
        state_next = upd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/upd_datapath.sv
// ---------------------------------------------------------------------------
// upd_datapath
// frame store, count, length, checksum, start code and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upd_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire upd_pkg::upd_cmd_t cmd,
  input  wire logic [7:0]        rx_byte,
  upd_cfg_if.sink                cfg,
  upd_out_if.source              dout,
  output upd_pkg::upd_sts_t      sts
);

  logic [7:0]                  frame_store [upd_pkg::BUF_SIZE];
  logic [upd_pkg::CNT_W-1:0]   byte_count;
  logic [7:0]                  frame_length;
  logic [7:0]                  running_sum;
  logic [7:0]                  start_code;
  logic [upd_pkg::IDX_W-1:0]   rd_idx;
  logic [7:0]                  rd_data;
  logic                        sum_bad;

  logic                        out_valid;
  logic [7:0]                  out_byte;
  logic                        out_has;
  logic                        out_status;
  logic                        out_last;

  logic [7:0]                  sum_before;
  logic [upd_pkg::CNT_W-1:0]   cnt_inc;
  logic [upd_pkg::CMP_W-1:0]   cnt_ext;
  logic [upd_pkg::CMP_W-1:0]   len_ext;
  logic                        start_bad;
  logic                        complete;
  logic                        wrap;
  logic                        mismatch;

  always_comb begin
    sum_before = (byte_count == '0) ? 8'd0 : running_sum;
    cnt_inc    = byte_count + 1'b1;
    cnt_ext    = upd_pkg::CMP_W'(cnt_inc);
    len_ext    = upd_pkg::CMP_W'(frame_length);
    start_bad  = (byte_count == '0) && (rx_byte != start_code);
    complete   = (cnt_ext > upd_pkg::CMP_W'(2)) && (cnt_ext == len_ext);
    wrap       = cnt_inc == upd_pkg::CNT_W'(upd_pkg::BUF_SIZE);
    mismatch   = sum_before != rx_byte;
  end

  assign sts.complete = complete;
  assign sts.single   = mismatch || (frame_length == 8'd3);
  assign sts.rd_last  = (upd_pkg::CMP_W'(rd_idx) + upd_pkg::CMP_W'(2)) == len_ext;
  assign sts.out_free = !out_valid || dout.ready;

  assign cfg.ready = 1'b1;

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.accept_byte) begin
      frame_store[byte_count[upd_pkg::IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= frame_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      start_code   <= upd_pkg::START_CODE_RST;
      rd_idx       <= upd_pkg::IDX_W'(2);
    end else begin
      if (cfg.valid) begin
        start_code <= cfg.data;
      end
      if (cmd.line_err) begin
        byte_count  <= '0;
        running_sum <= '0;
      end else if (cmd.accept_byte) begin
        if (cnt_inc == upd_pkg::CNT_W'(2)) begin
          frame_length <= rx_byte;
        end
        if (start_bad || complete || wrap) begin
          byte_count  <= '0;
          running_sum <= '0;
        end else begin
          byte_count  <= cnt_inc;
          running_sum <= sum_before + rx_byte;
        end
        if (complete) begin
          rd_idx <= upd_pkg::IDX_W'(2);
        end
      end
      if (cmd.load_payload) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_byte && complete) begin
      sum_bad <= mismatch;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_payload || cmd.load_single) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_payload) begin
      out_byte   <= rd_data;
      out_has    <= 1'b1;
      out_status <= upd_pkg::STATUS_GOOD;
      out_last   <= sts.rd_last;
    end else if (cmd.load_single) begin
      out_byte   <= 8'd0;
      out_has    <= 1'b0;
      out_status <= sum_bad ? upd_pkg::STATUS_BAD : upd_pkg::STATUS_GOOD;
      out_last   <= 1'b1;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.payload_byte = out_byte;
  assign dout.has_data     = out_has;
  assign dout.status       = out_status;
  assign dout.last         = out_last;

endmodule

`default_nettype wire

// File: rtl/uart_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// uart_packet_deframer_core
// start / length / checksum packet deframer on uart receive events
// ---------------------------------------------------------------------------
// din carries receive events: op 0 is a received byte, op 1 a line error
// that drops the partial frame. dout carries results, cfg writes the start
// code. every channel moves one transfer when valid and ready are high.
// a byte that does not complete a frame gives no result.
// the completing byte gives one result (checksum failure or empty payload)
// through the result register, or its payload bytes read back from the
// 64-entry frame store, one at a time through a read state and a load state
// while dout is ready, at a pace bounded by the single store read port; din
// is held off for the whole read-out and taken again once the last result is
// loaded, while that result still waits.
// a stall on dout holds the result register and pauses the read-out.
// reset (rst, synchronous) clears the frame count, length, checksum and the
// result valid flag and sets the start code to 'S'; the store is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "uart_packet_deframer_core_defines.svh"

module uart_packet_deframer_core (
  input wire logic  clk,
  input wire logic  rst,
  upd_in_if.sink    din,
  upd_out_if.source dout,
  upd_cfg_if.sink   cfg
);

  upd_pkg::upd_cmd_t cmd;
  upd_pkg::upd_sts_t sts;

  assign din.ready = cmd.in_ready;

  upd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_op    (din.op),
    .sts      (sts),
    .cmd      (cmd)
  );

  upd_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rx_byte (din.rx_byte),
    .cfg     (cfg),
    .dout    (dout),
    .sts     (sts)
  );

  `UPD_ASSERT_SAME(a_load_into_free, cmd.load_payload || cmd.load_single, sts.out_free)
  `UPD_ASSERT_NEXT(a_complete_holds_din, cmd.accept_byte && sts.complete, !din.ready)
  `UPD_ASSERT_NEXT(a_single_is_last, cmd.load_single, dout.valid && dout.last && !dout.has_data)

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the uart packet deframer core: a directed table of
// receive events, then random phases of good, corrupted, truncated and
// overflowing frames with line noise, under several start codes and idling
// mixes. every result transfer is compared with the table or a behavioural predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic       status;
    logic       last;
  } result_t;

  typedef struct {
    logic       op;
    logic [7:0] rx_byte;
    bit         typed;
    bit         typed_has_res;
    result_t    typed_res;
  } row_t;

  localparam int NUM_ROWS     = 22;
  localparam int PHASE_ITEMS  = 12;
  localparam int SETTLE_CYCLES = 16;

  logic clk = 1'b0;
  logic rst;

  upd_in_if  din_if ();
  upd_out_if dout_if ();
  upd_cfg_if cfg_if ();

  uart_packet_deframer_core u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  // predictor state
  logic [7:0]  start_code;
  logic [7:0]  frame_store [upd_pkg::BUF_SIZE];
  int unsigned byte_count;
  logic [7:0]  frame_length;
  logic [7:0]  running_sum;
  result_t     step_results [$];
  result_t     pending_results [$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int          frame_items;
  int          mismatch_count;
  result_t     want;

  row_t directed_rows [NUM_ROWS] = '{
    '{upd_pkg::OP_BYTE,  8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h53, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h03, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h56, 1'b1, 1'b1, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b1}},
    '{upd_pkg::OP_BYTE,  8'h53, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h03, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, upd_pkg::STATUS_BAD,  1'b1}},
    '{upd_pkg::OP_BYTE,  8'h53, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h05, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h57, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h53, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h06, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h11, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_ERROR, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h53, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h04, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'hAA, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_BYTE,  8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}},
    '{upd_pkg::OP_ERROR, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void deframe_step(input logic op, input logic [7:0] b);
    logic [7:0] sum_before;
    int         len;
    int         i;
    step_results.delete();
    if (op == upd_pkg::OP_ERROR) begin
      byte_count  = 0;
      running_sum = 8'h00;
      return;
    end
    if (byte_count == 0) running_sum = 8'h00;
    sum_before = running_sum;
    if (byte_count < upd_pkg::BUF_SIZE) frame_store[byte_count] = b;
    byte_count++;
    if (byte_count == 1 && b != start_code) begin
      byte_count  = 0;
      running_sum = 8'h00;
      return;
    end
    if (byte_count == 2) frame_length = b;
    if (byte_count > 2 && byte_count == frame_length) begin
      len         = frame_length;
      byte_count  = 0;
      running_sum = 8'h00;
      if (sum_before != b) begin
        step_results.push_back('{8'h00, 1'b0, upd_pkg::STATUS_BAD, 1'b1});
      end else if (len == 3) begin
        step_results.push_back('{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b1});
      end else begin
        for (i = 2; i + 1 < len && i < upd_pkg::BUF_SIZE; i++)
          step_results.push_back('{frame_store[i], 1'b1, upd_pkg::STATUS_GOOD,
                                   (i + 2 == len)});
      end
      return;
    end
    running_sum = sum_before + b;
    if (byte_count >= upd_pkg::BUF_SIZE) begin
      byte_count  = 0;
      running_sum = 8'h00;
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // one receive event, with random gaps before it
  task automatic drive_row(input row_t r);
    while ($urandom_range(99) < gap_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid   <= 1'b1;
    din_if.op      <= r.op;
    din_if.rx_byte <= r.rx_byte;
    do @(posedge clk); while (!din_if.ready);
    deframe_step(r.op, r.rx_byte);
    if (r.typed) begin
      if (r.typed_has_res) pending_results.push_back(r.typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic send(input logic op, input logic [7:0] b);
    row_t r;
    r = '{op, b, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}};
    drive_row(r);
    frame_items++;
  endtask

  task automatic send_noise();
    row_t       r;
    logic [7:0] b;
    if ($urandom_range(1)) begin
      do b = 8'($urandom_range(255)); while (b == start_code);
      r = '{upd_pkg::OP_BYTE, b, 1'b0, 1'b0, '{8'h00, 1'b0, upd_pkg::STATUS_GOOD, 1'b0}};
      drive_row(r);
    end else begin
      send(upd_pkg::OP_ERROR, 8'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(input int len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    int         k;
    sum = start_code + 8'(len);
    send(upd_pkg::OP_BYTE, start_code);
    send(upd_pkg::OP_BYTE, 8'(len));
    for (k = 0; k < len - 3; k++) begin
      b = 8'($urandom_range(255));
      sum += b;
      send(upd_pkg::OP_BYTE, b);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send(upd_pkg::OP_BYTE, sum);
  endtask

  // partial frame cut off by a line error
  task automatic send_broken();
    int len;
    int k;
    len = $urandom_range(4, 20);
    send(upd_pkg::OP_BYTE, start_code);
    send(upd_pkg::OP_BYTE, 8'(len));
    for (k = $urandom_range(0, len - 3); k > 0; k--)
      send(upd_pkg::OP_BYTE, 8'($urandom_range(255)));
    send(upd_pkg::OP_ERROR, 8'($urandom_range(255)));
  endtask

  // length that never completes, so the store fills and the frame is dropped
  task automatic send_overflow();
    int len;
    int k;
    len = $urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(65, 255);
    send(upd_pkg::OP_BYTE, start_code);
    send(upd_pkg::OP_BYTE, 8'(len));
    for (k = 2; k < upd_pkg::BUF_SIZE; k++) send(upd_pkg::OP_BYTE, 8'($urandom_range(255)));
  endtask

  task automatic write_start_code(input logic [7:0] code);
    din_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= code;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    start_code = code;
  endtask

  always @(posedge clk) begin
    dout_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: data %02h has %0b status %0b last %0b",
                             dout_if.payload_byte, dout_if.has_data, dout_if.status,
                             dout_if.last));
      end else begin
        want = pending_results.pop_front();
        if (dout_if.payload_byte !== want.payload_byte || dout_if.has_data !== want.has_data ||
            dout_if.status !== want.status || dout_if.last !== want.last)
          flag_error($sformatf({"mismatch: expected data %02h has %0b status %0b last %0b, ",
                                "got data %02h has %0b status %0b last %0b"},
                               want.payload_byte, want.has_data, want.status, want.last,
                               dout_if.payload_byte, dout_if.has_data, dout_if.status,
                               dout_if.last));
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int          ph;
    int unsigned r;
    logic [7:0]  code;
    rst            = 1'b1;
    din_if.valid   = 1'b0;
    din_if.op      = upd_pkg::OP_BYTE;
    din_if.rx_byte = 8'h00;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = 8'h00;
    gap_pct        = 35;
    stall_pct      = 58;
    mismatch_count = 0;
    frame_items    = 0;
    start_code     = upd_pkg::START_CODE_RST;
    byte_count     = 0;
    frame_length   = 8'h00;
    running_sum    = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) drive_row(directed_rows[i]);

    for (ph = 0; ph < 6; ph++) begin
      gap_pct   = (ph < 2) ? 35 : ((ph < 4) ? 58 : 0);
      stall_pct = (ph < 2) ? 58 : ((ph < 4) ? 35 : 0);
      case (ph)
        0:       code = 8'h00;
        1:       code = 8'hFF;
        3:       code = upd_pkg::START_CODE_RST;
        default: code = 8'($urandom_range(255));
      endcase
      write_start_code(code);
      frame_items = 0;
      if (ph == 1) send_overflow();
      if (ph == 3) send_frame(upd_pkg::BUF_SIZE, 1'b0);
      while (frame_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 70)
          send_frame(($urandom_range(19) == 0) ? $urandom_range(11, upd_pkg::BUF_SIZE)
                                                : $urandom_range(3, 10),
                     $urandom_range(99) < 15);
        else if (r < 82) send_broken();
        else if (r < 99) send_noise();
        else send_overflow();
      end
    end
    din_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
